// ===== hdl/fpd_pkg.sv =====
// Package for the fuzzy PD controller: sizes, actions, register indexes, reset values, commands.
// No dependencies.
package fpd_pkg;

	localparam int SETS_DEF = 7;
	localparam int CORNERS  = 3;

	typedef enum logic [1:0] {
		ACT_STEP  = 2'd0,
		ACT_RULE  = 2'd1,
		ACT_ESET  = 2'd2,
		ACT_DSET  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_ERROR_GAIN  = 2'd0,
		REG_DELTA_GAIN  = 2'd1,
		REG_OUTPUT_GAIN = 2'd2,
		REG_DRIVE_LIMIT = 2'd3
	} reg_idx_t;

	localparam logic [15:0] GAIN_RESET  = 16'd256;
	localparam logic [14:0] LIMIT_RESET = 15'd32767;

	// commands from controller to datapath
	typedef struct packed {
		logic start;     // latch input item, form error and change
		logic scale;     // apply input gains
		logic memb_ld;   // load triangle corners of set i into divider setup
		logic div_start; // start membership division
		logic memb_st;   // store membership
		logic acc_clr;   // clear accumulators
		logic pair_mul;  // ue*ud product
		logic pair_acc;  // accumulate product and rule
		logic fin_mul;   // |num| * output gain
		logic fin_div;   // start final divide
		logic fin_done;  // form result
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} sts_t;

endpackage

// ===== hdl/fuzzy_pd_controller.sv =====
// Fuzzy PD controller top level: stream ports, registers, output stage.
// Depends on fpd_pkg, fpd_ctrl, fpd_datapath.
// Timing: a table write is stored on accept and produces no item; a step result follows the
// membership divides, pair sums and final divide on the shared bit-serial divider.
// Throughput: one step at a time; s_tready is low while a step is in work or its result waits.
// Reset: arst_n clears registers to defaults, prev error to zero; tables stay undefined.
module fuzzy_pd_controller #(
	parameter int SETS = fpd_pkg::SETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // action[1:0], target, actual, table_index, table_value, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // drive[15:0], no_rule_fired, clamped, zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] eg_q, dg_q, og_q;
	logic [14:0] lim_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eg_q <= fpd_pkg::GAIN_RESET; dg_q <= fpd_pkg::GAIN_RESET;
			og_q <= fpd_pkg::GAIN_RESET; lim_q <= fpd_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fpd_pkg::REG_ERROR_GAIN:  eg_q <= cfg_data;
				fpd_pkg::REG_DELTA_GAIN:  dg_q <= cfg_data;
				fpd_pkg::REG_OUTPUT_GAIN: og_q <= cfg_data;
				fpd_pkg::REG_DRIVE_LIMIT: lim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic acc, busy, done, go;
	fpd_pkg::cmd_t cmd;
	fpd_pkg::sts_t sts;
	logic [$clog2(SETS)-1:0] ii, jj;
	logic signed [15:0] drive;
	logic nrf, clp;

	// done cycle: result not yet valid, so hold off the next item too
	assign s_tready = !busy && !m_tvalid && !done;
	assign acc      = s_tvalid && s_tready;
	assign go       = acc && (s_tdata[1:0] == fpd_pkg::ACT_STEP);

	fpd_ctrl #(.SETS(SETS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .sts(sts), .cmd(cmd),
		.idx_i(ii), .idx_j(jj), .busy(busy), .done(done)
	);

	fpd_datapath #(.SETS(SETS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .idx_i(ii), .idx_j(jj),
		.tbl_we(acc), .tbl_act(s_tdata[1:0]), .table_index(s_tdata[41:34]),
		.table_value(s_tdata[57:42]), .target(s_tdata[17:2]), .actual(s_tdata[33:18]),
		.error_gain(eg_q), .delta_gain(dg_q), .output_gain(og_q), .drive_limit(lim_q),
		.drive(drive), .no_rule_fired(nrf), .clamped(clp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end
	assign m_tdata = {6'b0, clp, nrf, drive};
endmodule

// ===== hdl/fpd_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing.
module fpd_div #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;

	assign trial    = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, dvs_q};
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-1:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== hdl/fpd_datapath.sv =====
// Datapath: tables, error/change, gain scaling, memberships, pair sums, final divide.
// Depends on fpd_pkg and fpd_div.
module fpd_datapath #(
	parameter int SETS = fpd_pkg::SETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fpd_pkg::cmd_t      cmd,
	output fpd_pkg::sts_t      sts,
	input  logic [$clog2(SETS)-1:0] idx_i,
	input  logic [$clog2(SETS)-1:0] idx_j,
	input  logic               tbl_we,
	input  logic [1:0]         tbl_act,
	input  logic [7:0]         table_index,
	input  logic signed [15:0] table_value,
	input  logic signed [15:0] target,
	input  logic signed [15:0] actual,
	input  logic [15:0]        error_gain,
	input  logic [15:0]        delta_gain,
	input  logic [15:0]        output_gain,
	input  logic [14:0]        drive_limit,
	output logic signed [15:0] drive,
	output logic               no_rule_fired,
	output logic               clamped
);
	localparam int NR = SETS * SETS;
	localparam int NC = SETS * fpd_pkg::CORNERS;
	// den <= NR * 4096 * 4096, |num| <= 8 * den, final dividend |num| * gain + den/2
	localparam int DENW = 25 + $clog2(NR);
	localparam int NUMW = DENW + 4;
	localparam int DW = DENW + 19;

	logic signed [3:0]  rule_mem [NR];
	logic signed [15:0] eset_mem [NC];
	logic signed [15:0] dset_mem [NC];
	logic [12:0]        ue_q [SETS];
	logic [12:0]        ud_q [SETS];

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			case (tbl_act)
				fpd_pkg::ACT_RULE: if (table_index < 8'(NR))
					rule_mem[$clog2(NR)'(table_index)] <= table_value[3:0];
				fpd_pkg::ACT_ESET: if (table_index < 8'(NC))
					eset_mem[$clog2(NC)'(table_index)] <= table_value;
				fpd_pkg::ACT_DSET: if (table_index < 8'(NC))
					dset_mem[$clog2(NC)'(table_index)] <= table_value;
				default: ;
			endcase
		end
	end

	// error and change
	logic signed [15:0] prev_q, err_q;
	logic signed [16:0] delta_q, diff;
	logic signed [15:0] err_sat;
	assign diff    = 17'(target) - 17'(actual);
	assign err_sat = (diff > 17'sd32767) ? 16'sh7fff :
	                 (diff < -17'sd32768) ? 16'sh8000 : diff[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.start) begin
			prev_q <= err_sat;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			err_q   <= err_sat;
			delta_q <= 17'(err_sat) - 17'(prev_q);
		end
	end

	// scaling: floor((v*g+32)/64), saturated
	function automatic logic signed [15:0] scale_sat(input logic signed [16:0] v,
	                                                 input logic [15:0] g);
		logic signed [34:0] p;
		logic signed [28:0] s;
		begin
			p = 35'(v) * $signed({1'b0, g}) + 35'sd32;
			s = p[34:6];
			if (s > 29'sd32767) scale_sat = 16'sh7fff;
			else if (s < -29'sd32768) scale_sat = 16'sh8000;
			else scale_sat = s[15:0];
		end
	endfunction

	logic signed [15:0] xe_q, xd_q;
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			xe_q <= scale_sat(17'(err_q), error_gain);
			xd_q <= scale_sat(delta_q, delta_gain);
		end
	end

	// membership: idx_j selects error (0) or delta (1) table
	logic signed [15:0] ca, cb, cc, x;
	logic [$clog2(NC)-1:0] base;
	assign base = $clog2(NC)'(idx_i) * $clog2(NC)'(fpd_pkg::CORNERS);
	assign x  = idx_j[0] ? xd_q : xe_q;
	assign ca = idx_j[0] ? dset_mem[base] : eset_mem[base];
	assign cb = idx_j[0] ? dset_mem[base + 1'b1] : eset_mem[base + 1'b1];
	assign cc = idx_j[0] ? dset_mem[base + 2'd2] : eset_mem[base + 2'd2];

	logic        mfix_q;
	logic [12:0] mval_q;
	logic [DW-1:0] mnum_q, mden_q;
	logic signed [16:0] xa, bx, cx, ba, cbd;
	assign xa  = 17'(x) - 17'(ca);
	assign ba  = 17'(cb) - 17'(ca);
	assign cx  = 17'(cc) - 17'(x);
	assign cbd = 17'(cc) - 17'(cb);
	assign bx  = 17'(x) - 17'(cb);

	always_ff @(posedge clk) begin
		if (cmd.memb_ld) begin
			mfix_q <= 1'b1;
			mval_q <= '0;
			mnum_q <= '0;
			mden_q <= DW'(1);
			if ((ca == cb && x <= ca) || (ca != cb && cb == cc && x >= cc)) begin
				mval_q <= 13'd4096;
			end else if (x >= ca && x <= cb && cb > ca) begin
				mfix_q <= 1'b0;
				mnum_q <= DW'({xa[15:0], 12'b0});
				mden_q <= DW'(ba[16:0]);
			end else if (bx > 0 && x <= cc && cc > cb) begin
				mfix_q <= 1'b0;
				mnum_q <= DW'({cx[15:0], 12'b0});
				mden_q <= DW'(cbd[16:0]);
			end
		end
	end

	// shared divider
	logic [DW-1:0] dv_a, dv_b, dv_q;
	logic          dv_busy;
	logic [DW-1:0] fnum_q;
	logic [DW-1:0] den_q;
	assign dv_a = cmd.fin_div ? fnum_q : mnum_q;
	assign dv_b = cmd.fin_div ? den_q : mden_q;

	fpd_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start | cmd.fin_div),
		.dividend(dv_a), .divisor(dv_b), .busy(dv_busy), .quotient(dv_q)
	);
	assign sts.div_busy = dv_busy;

	always_ff @(posedge clk) begin
		if (cmd.memb_st) begin
			if (idx_j[0]) ud_q[idx_i] <= mfix_q ? mval_q : dv_q[12:0];
			else ue_q[idx_i] <= mfix_q ? mval_q : dv_q[12:0];
		end
	end

	// pair accumulation
	logic [25:0]           w_s1;
	logic signed [3:0]     r_s1;
	logic signed [NUMW-1:0] num_q;
	logic [DENW-1:0]       den_acc;
	always_ff @(posedge clk) begin
		if (cmd.pair_mul) begin
			w_s1 <= ue_q[idx_i] * ud_q[idx_j];
			r_s1 <= rule_mem[$clog2(NR)'(idx_i) * $clog2(NR)'(SETS) + $clog2(NR)'(idx_j)];
		end
		if (cmd.acc_clr) begin
			num_q   <= '0;
			den_acc <= '0;
		end else if (cmd.pair_acc) begin
			num_q   <= num_q + NUMW'($signed({1'b0, w_s1})) * NUMW'(r_s1);
			den_acc <= den_acc + DENW'(w_s1);
		end
	end

	logic neg_q;
	logic [NUMW-1:0] mag;
	assign mag = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
	always_ff @(posedge clk) begin
		if (cmd.fin_mul) begin
			neg_q  <= num_q[NUMW-1];
			den_q  <= DW'(den_acc);
			fnum_q <= DW'(mag) * DW'(output_gain) + DW'(den_acc[DENW-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_done) begin
			if (den_q == '0) begin
				drive <= '0; no_rule_fired <= 1'b1; clamped <= 1'b0;
			end else begin
				no_rule_fired <= 1'b0;
				if (dv_q > DW'(drive_limit)) begin
					clamped <= 1'b1;
					drive   <= neg_q ? -$signed({1'b0, drive_limit}) : $signed({1'b0, drive_limit});
				end else begin
					clamped <= 1'b0;
					drive   <= neg_q ? -$signed(dv_q[15:0]) : $signed(dv_q[15:0]);
				end
			end
		end
	end
endmodule

// ===== hdl/fpd_ctrl.sv =====
// Sequencer for one control step: scale, memberships, pair sum, final divide.
// Depends on fpd_pkg.
module fpd_ctrl #(
	parameter int SETS = fpd_pkg::SETS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  fpd_pkg::sts_t sts,
	output fpd_pkg::cmd_t cmd,
	output logic [$clog2(SETS)-1:0] idx_i,
	output logic [$clog2(SETS)-1:0] idx_j,
	output logic          busy,
	output logic          done
);
	localparam int SW = $clog2(SETS);

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE, S_MLD, S_MDIV, S_MWAIT, S_MST, S_PMUL, S_PACC,
		S_FMUL, S_FDIV, S_FWAIT, S_FIN
	} state_t;

	state_t state_q;
	logic [SW-1:0] i_q, j_q;

	assign idx_i = i_q;
	assign idx_j = j_q;
	assign busy  = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_SCALE: cmd.scale = 1'b1;
			S_MLD:   cmd.memb_ld = 1'b1;
			S_MDIV:  cmd.div_start = 1'b1;
			S_MST:   cmd.memb_st = 1'b1;
			S_PMUL:  begin cmd.pair_mul = 1'b1; cmd.acc_clr = (i_q == '0 && j_q == '0); end
			S_PACC:  cmd.pair_acc = 1'b1;
			S_FMUL:  cmd.fin_mul = 1'b1;
			S_FDIV:  cmd.fin_div = 1'b1;
			S_FIN:   cmd.fin_done = 1'b1;
			default: cmd.start = go;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; i_q <= '0; j_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE:  if (go) begin state_q <= S_SCALE; i_q <= '0; j_q <= '0; end
				S_SCALE: state_q <= S_MLD;
				S_MLD:   state_q <= S_MDIV;
				S_MDIV:  state_q <= S_MWAIT;
				S_MWAIT: if (!sts.div_busy) state_q <= S_MST;
				S_MST: begin
					// j picks error (0) or delta (1) set
					if (j_q == '0) begin
						j_q <= SW'(1); state_q <= S_MLD;
					end else if (i_q != SW'(SETS - 1)) begin
						j_q <= '0; i_q <= i_q + 1'b1; state_q <= S_MLD;
					end else begin
						i_q <= '0; j_q <= '0; state_q <= S_PMUL;
					end
				end
				S_PMUL: state_q <= S_PACC;
				S_PACC: begin
					if (j_q != SW'(SETS - 1)) begin
						j_q <= j_q + 1'b1; state_q <= S_PMUL;
					end else if (i_q != SW'(SETS - 1)) begin
						j_q <= '0; i_q <= i_q + 1'b1; state_q <= S_PMUL;
					end else begin
						state_q <= S_FMUL;
					end
				end
				S_FMUL:  state_q <= S_FDIV;
				S_FDIV:  state_q <= S_FWAIT;
				S_FWAIT: if (!sts.div_busy) state_q <= S_FIN;
				S_FIN:   begin state_q <= S_IDLE; done <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/fpd_checker.sv =====
// Port checker for the fuzzy PD controller, bound to the top level.
// Depends on nothing.
module fpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result waits");
	a_nrf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0 && !m_tdata[17])
		else $error("no rule fired but drive set");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:18] == 6'd0) else $error("fill bits set");
endmodule

bind fuzzy_pd_controller fpd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/fuzzy_pd_controller_test.sv =====
// Self-checking bench for the fuzzy PD controller: table loads, control steps,
// register phases and random stalls, each result checked against a built-in predictor.
// Depends on fpd_pkg and fuzzy_pd_controller.
`timescale 1ns / 100ps

typedef struct {
	fpd_pkg::action_t   act;
	logic signed [15:0] target;
	logic signed [15:0] actual;
	logic [7:0]         idx;
	logic signed [15:0] val;
} fpd_item_t;

typedef struct {
	logic signed [15:0] drive;
	logic               no_fire;
	logic               clamped;
} drive_res_t;

class drive_scoreboard;
	localparam int NS = fpd_pkg::SETS_DEF;
	longint rules [NS*NS];
	longint esets [NS*fpd_pkg::CORNERS];
	longint dsets [NS*fpd_pkg::CORNERS];
	longint prev_err;
	longint err_gain, dlt_gain, out_gain, limit;
	drive_res_t expected_drives[$];
	int mismatches;

	function new();
		err_gain = fpd_pkg::GAIN_RESET; dlt_gain = fpd_pkg::GAIN_RESET;
		out_gain = fpd_pkg::GAIN_RESET;
		limit = fpd_pkg::LIMIT_RESET; prev_err = 0; mismatches = 0;
	endfunction

	function void set_reg(fpd_pkg::reg_idx_t r, logic [15:0] v);
		case (r)
			fpd_pkg::REG_ERROR_GAIN:  err_gain = v;
			fpd_pkg::REG_DELTA_GAIN:  dlt_gain = v;
			fpd_pkg::REG_OUTPUT_GAIN: out_gain = v;
			fpd_pkg::REG_DRIVE_LIMIT: limit = v[14:0];
			default: ;
		endcase
	endfunction

	function longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function longint to_universe(longint v, longint g);
		longint p, q;
		p = v * g + 32;
		q = p / 64;
		if ((p % 64) != 0 && p < 0) q--;
		return sat16(q);
	endfunction

	function longint grade(longint x, longint a, longint b, longint c);
		if (a == b) begin
			if (x <= a) return 4096;
		end else if (b == c) begin
			if (x >= c) return 4096;
		end
		if (x >= a && x <= b && b > a) return ((x - a) * 4096) / (b - a);
		if (x > b && x <= c && c > b) return ((c - x) * 4096) / (c - b);
		return 0;
	endfunction

	function void note(fpd_item_t it);
		longint err, dlt, xe, xd, num, den, w, q;
		longint ue [NS];
		longint ud [NS];
		logic [3:0] lv;
		drive_res_t r;
		case (it.act)
			fpd_pkg::ACT_RULE: begin
				lv = it.val[3:0];
				if (it.idx < NS*NS) rules[it.idx] = longint'($signed(lv));
			end
			fpd_pkg::ACT_ESET: if (it.idx < NS*fpd_pkg::CORNERS) esets[it.idx] = it.val;
			fpd_pkg::ACT_DSET: if (it.idx < NS*fpd_pkg::CORNERS) dsets[it.idx] = it.val;
			default: begin
				err = sat16(longint'(it.target) - longint'(it.actual));
				dlt = err - prev_err;
				prev_err = err;
				xe = to_universe(err, err_gain);
				xd = to_universe(dlt, dlt_gain);
				for (int i = 0; i < NS; i++) begin
					ue[i] = grade(xe, esets[3*i], esets[3*i+1], esets[3*i+2]);
					ud[i] = grade(xd, dsets[3*i], dsets[3*i+1], dsets[3*i+2]);
				end
				num = 0; den = 0;
				for (int i = 0; i < NS; i++)
					for (int j = 0; j < NS; j++) begin
						w = ue[i] * ud[j];
						num += w * rules[i*NS+j];
						den += w;
					end
				r.drive = 0; r.no_fire = 0; r.clamped = 0;
				if (den == 0) r.no_fire = 1;
				else begin
					q = ((num < 0 ? -num : num) * out_gain + den / 2) / den;
					if (q > limit) begin
						q = limit;
						r.clamped = 1;
					end
					r.drive = num < 0 ? -q : q;
				end
				expected_drives.push_back(r);
			end
		endcase
	endfunction

	function void check(logic [23:0] d);
		drive_res_t e;
		if (expected_drives.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result item %h", d);
			return;
		end
		e = expected_drives.pop_front();
		if (d[15:0] !== e.drive || d[16] !== e.no_fire || d[17] !== e.clamped) begin
			mismatches++;
			if (mismatches <= 10)
				$display("drive mismatch: exp %0d nf %b cl %b, got %0d nf %b cl %b",
					e.drive, e.no_fire, e.clamped, $signed(d[15:0]), d[16], d[17]);
		end
	endfunction
endclass

module fuzzy_pd_controller_test;
	localparam int NS = fpd_pkg::SETS_DEF;
	localparam int SETTLE = 900;
	localparam int WATCHDOG = 40000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // action, target, actual, table_index, table_value, zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // drive, no_rule_fired, clamped
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	drive_scoreboard sb;
	bit quiet;
	int stall_left;
	int idle_cycles;

	fuzzy_pd_controller dut (.*);

	initial begin
		clk = 0; arst_n = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
	end

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: random stall bursts until the quiet tail
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check(m_tdata);
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			m_tready <= 0;
		end else
			m_tready <= 1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(fpd_item_t it);
		logic [63:0] w;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		w = {6'b0, it.val, it.idx, it.actual, it.target, it.act};
		s_tvalid <= 1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		sb.note(it);
	endtask

	task automatic send_write(fpd_pkg::action_t a, logic [7:0] idx, logic [15:0] v);
		fpd_item_t it;
		it.act = a; it.idx = idx; it.val = v;
		it.target = 16'($urandom); it.actual = 16'($urandom);
		send(it);
	endtask

	task automatic send_step(logic [15:0] t, logic [15:0] a);
		fpd_item_t it;
		it.act = fpd_pkg::ACT_STEP; it.target = t; it.actual = a;
		it.idx = 8'($urandom); it.val = 16'($urandom);
		send(it);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.expected_drives.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(fpd_pkg::reg_idx_t r, logic [15:0] v);
		cfg_we <= 1; cfg_index <= r; cfg_data <= v;
		@(posedge clk);
		sb.set_reg(r, v);
	endtask

	task automatic set_gains(logic [15:0] eg, logic [15:0] dg, logic [15:0] og,
			logic [15:0] lim);
		drain();
		repeat (SETTLE) @(posedge clk);
		write_reg(fpd_pkg::REG_ERROR_GAIN, eg);
		write_reg(fpd_pkg::REG_DELTA_GAIN, dg);
		write_reg(fpd_pkg::REG_OUTPUT_GAIN, og);
		write_reg(fpd_pkg::REG_DRIVE_LIMIT, lim);
		cfg_we <= 0;
	endtask

	// triangles centred 2.0 apart in Q5.10, left shoulder always,
	// right shoulder and a reversed triangle on request
	task automatic load_tables(bit right_sh, bit reversed, bit jitter);
		int ctr, a, b, c;
		for (int k = 0; k < NS*NS; k++) send_write(fpd_pkg::ACT_RULE, 8'(k), 16'($urandom));
		for (int tbl = 0; tbl < 2; tbl++)
			for (int i = 0; i < NS; i++) begin
				ctr = (i - NS/2) * 2048 + (jitter ? $urandom_range(0, 600) - 300 : 0);
				a = ctr - 2048; b = ctr; c = ctr + 2048;
				if (i == 0) a = b;
				if (i == NS-1 && right_sh) c = b;
				if (i == 2 && reversed) begin
					a = ctr + 500; c = ctr - 500;
				end
				send_write(tbl ? fpd_pkg::ACT_DSET : fpd_pkg::ACT_ESET, 8'(3*i), 16'(a));
				send_write(tbl ? fpd_pkg::ACT_DSET : fpd_pkg::ACT_ESET, 8'(3*i+1), 16'(b));
				send_write(tbl ? fpd_pkg::ACT_DSET : fpd_pkg::ACT_ESET, 8'(3*i+2), 16'(c));
			end
	endtask

	task automatic random_items(int n, bit pause);
		int pick;
		logic [15:0] t;
		for (int k = 0; k < n; k++) begin
			if (pause && k == n/2) drain();
			pick = $urandom_range(0, 19);
			if (pick == 0)
				send_write(fpd_pkg::ACT_RULE, 8'($urandom), 16'($urandom));
			else if (pick == 1)
				send_write($urandom_range(0, 1) ? fpd_pkg::ACT_ESET : fpd_pkg::ACT_DSET,
					8'($urandom_range(0, 1) ? $urandom_range(0, 3*NS-1) : $urandom),
					16'($urandom));
			else if (pick < 6)
				send_step(16'($urandom), 16'($urandom));
			else begin
				t = 16'($urandom_range(0, 4000) - 2000);
				send_step(t, 16'(t + $urandom_range(0, 2000) - 1000));
			end
		end
	endtask

	initial begin
		sb = new();
		quiet = 0;
		stall_left = 0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default registers, no right shoulder so large errors fire nothing
		load_tables(1'b0, 1'b1, 1'b0);
		send_write(fpd_pkg::ACT_RULE, 8'd49, 16'h0007);
		send_write(fpd_pkg::ACT_ESET, 8'd255, 16'h8000);
		send_write(fpd_pkg::ACT_DSET, 8'd21, 16'h7fff);
		send_step(16'sd0, 16'sd0);
		send_step(16'h7fff, 16'h8000);
		send_step(16'h8000, 16'h7fff);
		send_step(16'h7fff, 16'h0000);
		send_step(16'sd300, 16'sd0);
		send_step(16'sd300, 16'sd0);
		send_step(-16'sd700, 16'sd100);
		send_step(16'sd2500, 16'sd0);
		send_step(16'hffff, 16'h0000);

		set_gains(16'd0, 16'd0, 16'd0, 16'd0);
		send_step(16'sd1000, 16'sd0);
		send_step(-16'sd1000, 16'sd0);
		random_items(60, 1'b0);

		set_gains(16'hffff, 16'hffff, 16'hffff, 16'h7fff);
		load_tables(1'b1, 1'b0, 1'b1);
		random_items(150, 1'b1);

		set_gains(16'd512, 16'd128, 16'hffff, 16'd300);
		load_tables(1'b1, 1'b1, 1'b1);
		random_items(150, 1'b0);

		set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		load_tables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
		random_items(150, 1'b0);

		quiet = 1;
		set_gains(16'd256, 16'd384, 16'd1024, 16'd20000);
		load_tables(1'b1, 1'b0, 1'b1);
		random_items(150, 1'b0);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_drives.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
